@@ src/mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared types, register map, reset values and helpers.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // Design defaults
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF  = 27;

  // Coordinate and product widths
  localparam int unsigned ZW = 32;
  localparam int unsigned PW = 2 * ZW;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

  // Reset values (-2.0, -1.5, 2^-8, 2^-8 in Q5.27; 256 steps)
  localparam logic signed [31:0] X_ORIGIN_RST = -32'sd268435456;
  localparam logic signed [31:0] Y_ORIGIN_RST = -32'sd201326592;
  localparam logic [30:0]        X_STEP_RST   = 31'd524288;
  localparam logic [30:0]        Y_STEP_RST   = 31'd524288;
  localparam logic [15:0]        MAX_ITER_RST = 16'd256;

  // Point classes
  localparam logic [1:0] CLS_EARLY    = 2'd0;
  localparam logic [1:0] CLS_LAST     = 2'd1;
  localparam logic [1:0] CLS_INTERIOR = 2'd2;

  typedef struct packed {
    logic signed [31:0] x_origin;
    logic signed [31:0] y_origin;
    logic [30:0]        x_step;
    logic [30:0]        y_step;
    logic [15:0]        max_iterations;
  } cfg_t;

  // Clamp a wide signed value into the 32-bit coordinate range
  function automatic logic signed [ZW-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = {{(PW-ZW+1){1'b0}}, {(ZW-1){1'b1}}};
    lo = {{(PW-ZW+1){1'b1}}, {(ZW-1){1'b0}}};
    if (v > hi) begin
      sat32 = {1'b0, {(ZW-1){1'b1}}};
    end else if (v < lo) begin
      sat32 = {1'b1, {(ZW-1){1'b0}}};
    end else begin
      sat32 = v[ZW-1:0];
    end
  endfunction

endpackage

@@ src/mbe_cfg.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time configuration registers
// Five write-only registers on a valid/ready channel.
// ----------------------------------------------------------------------------
module mbe_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output mbe_pkg::cfg_t                    cfg_o
);
  import mbe_pkg::*;

  cfg_t cfg_q;

  // Always able to take a write
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin       <= X_ORIGIN_RST;
      cfg_q.y_origin       <= Y_ORIGIN_RST;
      cfg_q.x_step         <= X_STEP_RST;
      cfg_q.y_step         <= Y_STEP_RST;
      cfg_q.max_iterations <= MAX_ITER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_X_ORIGIN: cfg_q.x_origin       <= cfg_data_i;
        REG_Y_ORIGIN: cfg_q.y_origin       <= cfg_data_i;
        REG_X_STEP:   cfg_q.x_step         <= cfg_data_i[30:0];
        REG_Y_STEP:   cfg_q.y_step         <= cfg_data_i[30:0];
        REG_MAX_ITER: cfg_q.max_iterations <= cfg_data_i[15:0];
        default: ; // unmapped index, dropped
      endcase
    end
  end

endmodule

@@ src/mbe_mul.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time shared multiplier
// Signed 32x32 multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
module mbe_mul (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [mbe_pkg::ZW-1:0]    a_i,
  input  logic signed [mbe_pkg::ZW-1:0]    b_i,
  output logic signed [mbe_pkg::PW-1:0]    p_o
);
  import mbe_pkg::*;

  logic signed [PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

@@ src/mandelbrot_escape_time.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time engine
// Iterates z = z*z + c for one pixel on a single shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  - Input request: pixel_col_i/pixel_row_i, taken when in_valid_i is high
//    and in_stall_o is low. in_stall_o is high from the accept until the
//    result has been moved into the output register.
//  - Output request: iter_count_o, point_class_o, final_re_o, final_im_o,
//    held while out_valid_o is high and out_stall_i is high. A new pixel can
//    be accepted while the previous result still waits at the output.
//  - Config: cfg_valid_i/cfg_ready_o with cfg_index_i/cfg_data_i, write only
//    while no pixel is in flight. cfg_ready_o is always high.
//  - Sequence: an accepted pixel first forms c, then runs steps until it
//    hits the limit or escapes. The 32x32 multiplier is shared: c takes 2
//    products, each step needs zr*zr, zi*zi and zr*zi, so a step runs the
//    3 multiplies and then the update. The default limit is 256 steps.
//  - A stalled receiver holds the result in the output register; a finished
//    pixel then waits in its done state until the register frees up.
//  - Reset clears control state and loads the default view registers.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
  parameter int unsigned COORD_BITS = mbe_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // pixel input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [COORD_BITS-1:0]            pixel_col_i,
  input  logic [COORD_BITS-1:0]            pixel_row_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [15:0]                      iter_count_o,
  output logic [1:0]                       point_class_o,
  output logic signed [31:0]               final_re_o,
  output logic signed [31:0]               final_im_o,
  // configuration
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mbe_pkg::*;

  // |z|^2 > 4.0 in Q.(2*FRAC_BITS); above 63 bits no point can escape
  localparam bit             CAN_ESCAPE = (2 * FRAC_BITS + 2) <= 63;
  localparam logic [PW-1:0]  ESC_LIMIT  =
      CAN_ESCAPE ? (64'd1 << ((2 * FRAC_BITS + 2) % 64)) : '0;

  // Sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CRE   = 4'd1;  // col * x_step
  localparam logic [3:0] S_CIM   = 4'd2;  // c_re, row * y_step
  localparam logic [3:0] S_CFIN  = 4'd3;  // c_im
  localparam logic [3:0] S_SQRE  = 4'd4;  // limit check, zr*zr
  localparam logic [3:0] S_SQIM  = 4'd5;  // zi*zi
  localparam logic [3:0] S_ESC   = 4'd6;  // escape test, zr*zi
  localparam logic [3:0] S_UPD   = 4'd7;  // new z
  localparam logic [3:0] S_DONE  = 4'd8;  // hand off result

  cfg_t cfg;

  mbe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  logic [3:0]              state_q, state_d;
  logic [COORD_BITS-1:0]   col_q, row_q;
  logic signed [ZW-1:0]    cre_q, cim_q;
  logic signed [ZW-1:0]    zr_q, zi_q;
  logic signed [PW-1:0]    sr_q;
  logic signed [PW-1:0]    diff_q;
  logic [15:0]             iter_q;

  logic                    out_valid_q;
  logic [15:0]             iter_out_q;
  logic [1:0]              cls_out_q;
  logic signed [ZW-1:0]    re_out_q, im_out_q;

  // Shared multiplier
  logic                    mul_en;
  logic signed [ZW-1:0]    mul_a, mul_b;
  logic signed [PW-1:0]    prod;

  mbe_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    mul_en = 1'b1;
    mul_a  = zr_q;
    mul_b  = zi_q;
    case (state_q)
      S_CRE: begin
        mul_a = {1'b0, cfg.x_step};
        mul_b = {{(ZW-COORD_BITS){1'b0}}, col_q};
      end
      S_CIM: begin
        mul_a = {1'b0, cfg.y_step};
        mul_b = {{(ZW-COORD_BITS){1'b0}}, row_q};
      end
      S_SQRE: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      S_SQIM: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      S_ESC: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Datapath helpers
  logic                    in_acc;
  logic                    out_free;
  logic                    at_limit;
  logic [PW-1:0]           mag;
  logic                    escaped;
  logic signed [PW-1:0]    c_sum;
  logic signed [PW-1:0]    re_next, im_next;
  logic [1:0]              cls;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign at_limit = iter_q >= cfg.max_iterations;
  // sr + si <= 2^63 always fits unsigned
  assign mag      = $unsigned(sr_q) + $unsigned(prod);
  assign escaped  = CAN_ESCAPE && (mag > ESC_LIMIT);

  // origin + index*step; product is nonnegative and below 2^(31+COORD_BITS)
  assign c_sum = (state_q == S_CIM)
               ? ({{(PW-ZW){cfg.x_origin[ZW-1]}}, cfg.x_origin} + prod)
               : ({{(PW-ZW){cfg.y_origin[ZW-1]}}, cfg.y_origin} + prod);

  // floor back to FRAC_BITS, then add c
  assign re_next = (diff_q >>> FRAC_BITS) + $signed({{(PW-ZW){cre_q[ZW-1]}}, cre_q});
  assign im_next = (prod >>> (FRAC_BITS - 1)) + $signed({{(PW-ZW){cim_q[ZW-1]}}, cim_q});

  always_comb begin
    if (iter_q == cfg.max_iterations) begin
      cls = CLS_INTERIOR;
    end else if (({1'b0, iter_q} + 17'd1) == {1'b0, cfg.max_iterations}) begin
      cls = CLS_LAST;
    end else begin
      cls = CLS_EARLY;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_CRE;
      S_CRE:  state_d = S_CIM;
      S_CIM:  state_d = S_CFIN;
      S_CFIN: state_d = S_SQRE;
      S_SQRE: state_d = at_limit ? S_DONE : S_SQIM;
      S_SQIM: state_d = S_ESC;
      S_ESC:  state_d = escaped ? S_DONE : S_UPD;
      S_UPD:  state_d = S_SQRE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        iter_q <= '0;
      end else if (state_q == S_UPD) begin
        iter_q <= iter_q + 16'd1;
      end
    end
  end

  // Working registers (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q <= pixel_col_i;
      row_q <= pixel_row_i;
      zr_q  <= '0;
      zi_q  <= '0;
    end
    if (state_q == S_CIM)  cre_q  <= sat32(c_sum);
    if (state_q == S_CFIN) cim_q  <= sat32(c_sum);
    if (state_q == S_SQIM) sr_q   <= prod;
    if (state_q == S_ESC)  diff_q <= sr_q - prod;
    if (state_q == S_UPD) begin
      zr_q <= sat32(re_next);
      zi_q <= sat32(im_next);
    end
  end

  // Output register
  logic load_out;
  assign load_out = (state_q == S_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      iter_out_q <= iter_q;
      cls_out_q  <= cls;
      re_out_q   <= zr_q;
      im_out_q   <= zi_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign iter_count_o  = iter_out_q;
  assign point_class_o = cls_out_q;
  assign final_re_o    = re_out_q;
  assign final_im_o    = im_out_q;

  // Checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_CRE)
    else $error("accepted pixel did not start the sequencer");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside done state");

  a_iter_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> iter_q < cfg.max_iterations)
    else $error("step taken past the iteration limit");

endmodule
